>>> sv/bcts_pkg.sv
// Shared types, constants and helper functions of the bucketed code table search unit.
`default_nettype none

package bcts_pkg;

    // Field widths of the item and result beats.
    localparam int KIND_W  = 2;
    localparam int SLOT_W  = 10;
    localparam int LEN_W   = 17;
    localparam int ESLOT_W = 16;
    localparam int CODE_W  = 32;
    localparam int RES_W   = 16;

    // Unwrapped search indices stay below two to the eighteenth.
    localparam int XW    = 18;
    // Counter width for the reduction steps, which never exceed XW.
    localparam int CNT_W = 5;

    localparam int NUM_BUCKETS        = 729;
    localparam int BUCKET_COLS        = 27;
    localparam int ENTRY_CAPACITY_DEF = 65536;

    localparam logic [7:0] CHAR_A       = 8'h61;
    localparam logic [7:0] CHAR_Z       = 8'h7A;
    localparam logic [4:0] LETTER_OTHER = 5'd26;

    // Item kinds; the remaining code is ignored.
    localparam logic [KIND_W-1:0] KIND_BUCKET = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] length;
    } bkt_ent_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        bkt_ent_t          data;
    } bkt_wr_t;

    function automatic logic [4:0] letter_index(input logic [7:0] ch);
        logic [7:0] diff;
        diff = ch - CHAR_A;
        if (ch < CHAR_A || ch > CHAR_Z) begin
            return LETTER_OTHER;
        end
        return diff[4:0];
    endfunction

    function automatic logic [SLOT_W-1:0] bucket_index(input logic [CODE_W-1:0] code);
        logic [SLOT_W-1:0] row;
        logic [SLOT_W-1:0] col;
        row = SLOT_W'(letter_index(code[31:24]));
        col = SLOT_W'(letter_index(code[23:16]));
        return row * SLOT_W'(BUCKET_COLS) + col;
    endfunction

endpackage

`default_nettype wire

>>> sv/bucketed_code_table_search_unit.sv
// Top level of the bucketed code table search unit: sequencer and shared compare/subtract unit.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+------------------------------------------------
//  item     | in        | in_valid / in_stall | kind, bucket_slot, bucket_start, bucket_length,
//           |           |                     | entry_slot, entry_code, query_code
//  result   | out       | out_valid/out_stall | found, first_match_res
//
// A lookup reads its bucket, then runs binary search probes, and after a hit steps back
// over duplicate entries; an empty bucket answers without reading the store. Every store
// address and the reported index pass through modulo reduction steps, which are skipped
// when ENTRY_CAPACITY is a power of two or at least 2**18.
// Every probe goes through the single read port of the code store, which sets the pace.
// Reset clears the sequencer and the result registers; both memories are undefined
// until loaded. A waiting result does not block load beats, and a finished lookup holds
// in its final state until the result register is free.
`default_nettype none

module bucketed_code_table_search_unit #(
    parameter int ENTRY_CAPACITY = bcts_pkg::ENTRY_CAPACITY_DEF
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_stall,
    input  wire  [bcts_pkg::KIND_W-1:0]   kind,
    input  wire  [bcts_pkg::SLOT_W-1:0]   bucket_slot,
    input  wire  [bcts_pkg::LEN_W-1:0]    bucket_start,
    input  wire  [bcts_pkg::LEN_W-1:0]    bucket_length,
    input  wire  [bcts_pkg::ESLOT_W-1:0]  entry_slot,
    input  wire  [bcts_pkg::CODE_W-1:0]   entry_code,
    input  wire  [bcts_pkg::CODE_W-1:0]   query_code,
    output logic                          out_valid,
    input  wire                           out_stall,
    output logic                          found,
    output logic [bcts_pkg::RES_W-1:0]    first_match_res
);
    import bcts_pkg::*;

    localparam int AW = $clog2(ENTRY_CAPACITY);
    // Bit length of the capacity, used to size the reduction sweep.
    localparam int CAP_BITS = $clog2(ENTRY_CAPACITY + 1);
    localparam bit IS_POW2 = ((ENTRY_CAPACITY & (ENTRY_CAPACITY - 1)) == 0);
    // Indices below 2**XW need no reduction once the capacity reaches that size.
    localparam bit NEED_RED = !IS_POW2 && (CAP_BITS <= XW);
    localparam int RED_TOP = NEED_RED ? (XW - CAP_BITS) : 0;
    localparam logic [XW-1:0] CAP_X = XW'(ENTRY_CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BKT,
        S_MID,
        S_RED,
        S_ADDR,
        S_RD,
        S_SCAN,
        S_DONE
    } state_t;

    // What the reduced address in x_reg is for.
    typedef enum logic [1:0] {
        P_WRITE,
        P_PROBE,
        P_SCAN,
        P_FINAL
    } purpose_t;

    state_t            state_reg, state_next;
    purpose_t          purpose_reg, purpose_next;
    logic [CNT_W-1:0]  red_cnt_reg, red_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              hit_reg, hit_next;

    logic [XW-1:0]     lo_reg, lo_next;
    logic [XW-1:0]     hi_reg, hi_next;
    logic [XW-1:0]     pos_reg, pos_next;
    logic [XW-1:0]     x_reg, x_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic              found_reg, found_next;
    logic [RES_W-1:0]  fmr_reg, fmr_next;

    logic              in_accept;
    logic              out_free;
    bkt_wr_t           bkt_wr;
    bkt_ent_t          bkt_rd;
    logic [XW:0]       mid_sum;
    logic [XW-1:0]     mid;
    logic [XW-1:0]     red_sub;
    logic [XW+AW-1:0]  x_ext;
    logic [AW-1:0]     mem_addr;
    logic [AW+RES_W-1:0] res_ext;
    logic              ram_we;
    logic              ram_re;
    logic [CODE_W-1:0] ram_rd_data;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Bucket loads go straight to the table; lookups read the selected bucket at once.
    always_comb
    begin
        bkt_wr.en          = in_accept && (kind == KIND_BUCKET) &&
                             (bucket_slot < SLOT_W'(NUM_BUCKETS));
        bkt_wr.addr        = bucket_slot;
        bkt_wr.data.start  = bucket_start;
        bkt_wr.data.length = bucket_length;
    end

    bcts_bucket_ram u_bucket_ram (
        .clk     (clk),
        .wr      (bkt_wr),
        .rd_addr (bucket_index(query_code)),
        .rd_data (bkt_rd)
    );

    // Shared datapath pieces: midpoint adder, shifted-capacity subtractor, address slice.
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[XW:1];
    assign red_sub  = CAP_X << red_cnt_reg;
    assign x_ext    = {{AW{1'b0}}, x_reg};
    assign mem_addr = x_ext[AW-1:0];
    assign res_ext  = {{RES_W{1'b0}}, mem_addr};

    assign ram_we = (state_reg == S_ADDR) && (purpose_reg == P_WRITE);
    assign ram_re = (state_reg == S_ADDR) &&
                    ((purpose_reg == P_PROBE) || (purpose_reg == P_SCAN));

    bcts_code_ram #(
        .DEPTH (ENTRY_CAPACITY),
        .AW    (AW)
    ) u_code_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (mem_addr),
        .wr_data (code_reg),
        .rd_en   (ram_re),
        .rd_addr (mem_addr),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        purpose_next   = purpose_reg;
        red_cnt_next   = red_cnt_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        pos_next       = pos_reg;
        x_next         = x_reg;
        code_next      = code_reg;
        res_next       = res_reg;
        found_next     = found_reg;
        fmr_next       = fmr_reg;

        if (out_valid_reg && !out_stall) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && (kind == KIND_ENTRY)) begin
                    x_next       = XW'(entry_slot);
                    code_next    = entry_code;
                    purpose_next = P_WRITE;
                    red_cnt_next = CNT_W'(RED_TOP);
                    state_next   = NEED_RED ? S_RED : S_ADDR;
                end else if (in_accept && (kind == KIND_LOOKUP)) begin
                    code_next  = query_code;
                    state_next = S_BKT;
                end
            end
            S_BKT:
            begin
                lo_next  = XW'(bkt_rd.start);
                hi_next  = XW'(bkt_rd.start) + XW'(bkt_rd.length);
                hit_next = 1'b0;
                res_next = '0;
                if (bkt_rd.length == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                if (lo_reg < hi_reg) begin
                    x_next       = mid;
                    pos_next     = mid;
                    purpose_next = P_PROBE;
                    red_cnt_next = CNT_W'(RED_TOP);
                    state_next   = NEED_RED ? S_RED : S_ADDR;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RED:
            begin
                if (x_reg >= red_sub) begin
                    x_next = x_reg - red_sub;
                end
                if (red_cnt_reg == '0) begin
                    state_next = S_ADDR;
                end else begin
                    red_cnt_next = red_cnt_reg - CNT_W'(1);
                end
            end
            S_ADDR:
            begin
                case (purpose_reg)
                    P_WRITE: state_next = S_IDLE;
                    P_FINAL:
                    begin
                        res_next   = res_ext[RES_W-1:0];
                        hit_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    default: state_next = S_RD;
                endcase
            end
            S_RD:
            begin
                if (purpose_reg == P_SCAN) begin
                    if (ram_rd_data == code_reg) begin
                        pos_next   = pos_reg - XW'(1);
                        state_next = S_SCAN;
                    end else begin
                        x_next       = pos_reg;
                        purpose_next = P_FINAL;
                        red_cnt_next = CNT_W'(RED_TOP);
                        state_next   = NEED_RED ? S_RED : S_ADDR;
                    end
                end else if (ram_rd_data < code_reg) begin
                    lo_next    = pos_reg + XW'(1);
                    state_next = S_MID;
                end else if (ram_rd_data > code_reg) begin
                    hi_next    = pos_reg;
                    state_next = S_MID;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                red_cnt_next = CNT_W'(RED_TOP);
                state_next   = NEED_RED ? S_RED : S_ADDR;
                if (pos_reg == '0) begin
                    x_next       = pos_reg;
                    purpose_next = P_FINAL;
                end else begin
                    x_next       = pos_reg - XW'(1);
                    purpose_next = P_SCAN;
                end
            end
            S_DONE:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    found_next     = hit_reg;
                    fmr_next       = hit_reg ? res_reg : '0;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            purpose_reg   <= P_WRITE;
            red_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            fmr_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            purpose_reg   <= purpose_next;
            red_cnt_reg   <= red_cnt_next;
            out_valid_reg <= out_valid_next;
            hit_reg       <= hit_next;
            found_reg     <= found_next;
            fmr_reg       <= fmr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        pos_reg   <= pos_next;
        x_reg     <= x_next;
        code_reg  <= code_next;
        res_reg   <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign first_match_res = fmr_reg;

`ifndef SYNTHESIS
    // A miss always reports index zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (first_match_res == '0))
        else $error("miss reported with nonzero index");

    // The code store is never read and written in the same cycle.
    a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("code store read and write collide");

    // Every store access lands inside the capacity.
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we || ram_re) |-> (x_reg < XW'(ENTRY_CAPACITY) || !NEED_RED))
        else $error("store address not reduced below capacity");

    // The search window never inverts.
    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MID) |-> (lo_reg <= hi_reg))
        else $error("search window inverted");

    // An accepted lookup reads its bucket in the next cycle.
    a_lookup_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (kind == KIND_LOOKUP)) |=> (state_reg == S_BKT))
        else $error("lookup did not start with its bucket read");
`endif

endmodule

`default_nettype wire

>>> sv/bcts_bucket_ram.sv
// Bucket table memory: one write port and one registered read port.
`default_nettype none

module bcts_bucket_ram (
    input  wire                          clk,
    input  wire bcts_pkg::bkt_wr_t       wr,
    input  wire [bcts_pkg::SLOT_W-1:0]   rd_addr,
    output bcts_pkg::bkt_ent_t           rd_data
);
    import bcts_pkg::*;

    bkt_ent_t mem [NUM_BUCKETS];
    bkt_ent_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/bcts_code_ram.sv
// Code store memory: one write port and one registered read port.
`default_nettype none

module bcts_code_ram #(
    parameter int DEPTH = bcts_pkg::ENTRY_CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire [AW-1:0]                 wr_addr,
    input  wire [bcts_pkg::CODE_W-1:0]   wr_data,
    input  wire                          rd_en,
    input  wire [AW-1:0]                 rd_addr,
    output logic [bcts_pkg::CODE_W-1:0]  rd_data
);
    import bcts_pkg::*;

    logic [CODE_W-1:0] mem [DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bucketed code table search unit, with its own dictionary model.
module testbench;
    import bcts_pkg::*;

    localparam int CAPACITY        = ENTRY_CAPACITY_DEF;
    localparam int TARGET_ITEMS    = 1450;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int PRESSURE_AFTER  = 150;
    localparam int PRESSURE_CYCLES = 1500;
    localparam int MAX_REPORTS     = 10;
    localparam int POOL_DEPTH      = 200;

    // The fourth kind code is not used by the block; beats of that kind are dropped.
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

    // One input beat as the sender queues it. Fields that the kind does not use still
    // carry random values, so the block must ignore them.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOT_W-1:0]  bslot;
        logic [LEN_W-1:0]   bstart;
        logic [LEN_W-1:0]   blen;
        logic [ESLOT_W-1:0] eslot;
        logic [CODE_W-1:0]  ecode;
        logic [CODE_W-1:0]  qcode;
    } beat_t;

    // The answer that one lookup should produce.
    typedef struct packed {
        logic              hit;
        logic [RES_W-1:0]  index;
        logic [CODE_W-1:0] query;
    } lookup_res_t;

    // Outcome of a dictionary search in the model. A search that would read a bucket or
    // a store entry that was never loaded reports which one, so that the stimulus can
    // load it first; the block itself never sees such a read.
    typedef enum logic [1:0] {
        SEARCH_DONE,
        NEED_BUCKET,
        NEED_ENTRY
    } search_stat_e;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [KIND_W-1:0]  kind = '0;
    logic [SLOT_W-1:0]  bucket_slot = '0;
    logic [LEN_W-1:0]   bucket_start = '0;
    logic [LEN_W-1:0]   bucket_length = '0;
    logic [ESLOT_W-1:0] entry_slot = '0;
    logic [CODE_W-1:0]  entry_code = '0;
    logic [CODE_W-1:0]  query_code = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               found;
    logic [RES_W-1:0]   first_match_res;

    // Model of the bucket table and the code store, with a flag per location that tells
    // whether it has been loaded.
    logic [LEN_W-1:0]  tbl_start [NUM_BUCKETS];
    logic [LEN_W-1:0]  tbl_len [NUM_BUCKETS];
    bit                tbl_known [NUM_BUCKETS];
    logic [CODE_W-1:0] store_code [CAPACITY];
    bit                store_known [CAPACITY];

    beat_t             stim_beats [$];
    lookup_res_t       awaited_lookups [$];
    logic [CODE_W-1:0] code_pool [$];

    int    item_count = 0;
    int    mismatches = 0;
    int    results_seen = 0;
    int    cycles = 0;
    int    send_gap = 0;
    int    send_burst = 0;
    int    hold_count = 0;
    bit    pressure_done = 1'b0;
    logic  in_taken = 1'b0;
    beat_t drive_beat;
    lookup_res_t seen_lookup;

    bucketed_code_table_search_unit #(
        .ENTRY_CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .bucket_slot(bucket_slot),
        .bucket_start(bucket_start),
        .bucket_length(bucket_length),
        .entry_slot(entry_slot),
        .entry_code(entry_code),
        .query_code(query_code),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .found(found),
        .first_match_res(first_match_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Letters a to z select rows and columns 0 to 25; every other byte lands in 26.
    function automatic int letter_of(input logic [7:0] ch);
        if (ch >= CHAR_A && ch <= CHAR_Z)
        begin
            return int'(ch) - int'(CHAR_A);
        end
        return 26;
    endfunction

    function automatic int bucket_of(input logic [CODE_W-1:0] code);
        return letter_of(code[31:24]) * BUCKET_COLS + letter_of(code[23:16]);
    endfunction

    // Binary search of the query's bucket, then a backward walk over equal codes. The
    // indices run unwrapped and every store read wraps at the capacity.
    function automatic search_stat_e search_dictionary(input logic [CODE_W-1:0] q,
                                                       output lookup_res_t res,
                                                       output int need_at);
        int slot;
        int lo;
        int hi;
        int mid;
        int pos;
        int addr;
        bit hit;
        bit scanning;
        res.query = q;
        res.hit = 1'b0;
        res.index = '0;
        need_at = 0;
        slot = bucket_of(q);
        if (!tbl_known[slot])
        begin
            need_at = slot;
            return NEED_BUCKET;
        end
        lo = int'(tbl_start[slot]);
        hi = lo + int'(tbl_len[slot]);
        hit = 1'b0;
        pos = 0;
        while (lo < hi && !hit)
        begin
            mid = (lo + hi) / 2;
            addr = mid % CAPACITY;
            if (!store_known[addr])
            begin
                need_at = addr;
                return NEED_ENTRY;
            end
            if (store_code[addr] < q)
            begin
                lo = mid + 1;
            end
            else if (store_code[addr] > q)
            begin
                hi = mid;
            end
            else
            begin
                hit = 1'b1;
                pos = mid;
            end
        end
        // The walk back may leave the bucket; it never goes below index 0.
        scanning = hit;
        while (scanning && pos > 0)
        begin
            addr = (pos - 1) % CAPACITY;
            if (!store_known[addr])
            begin
                need_at = addr;
                return NEED_ENTRY;
            end
            if (store_code[addr] == q)
            begin
                pos--;
            end
            else
            begin
                scanning = 1'b0;
            end
        end
        res.hit = hit;
        res.index = hit ? RES_W'(pos % CAPACITY) : '0;
        return SEARCH_DONE;
    endfunction

    // Queues a beat for the sender and applies it to the model in acceptance order.
    // Lookups reach here only once their whole search path is loaded.
    function automatic void queue_beat(input beat_t b);
        lookup_res_t res;
        int unused_at;
        case (b.kind)
            KIND_BUCKET:
            begin
                if (b.bslot < NUM_BUCKETS)
                begin
                    tbl_start[b.bslot] = b.bstart;
                    tbl_len[b.bslot] = b.blen;
                    tbl_known[b.bslot] = 1'b1;
                end
            end
            KIND_ENTRY:
            begin
                store_code[b.eslot] = b.ecode;
                store_known[b.eslot] = 1'b1;
            end
            KIND_LOOKUP:
            begin
                void'(search_dictionary(b.qcode, res, unused_at));
                awaited_lookups.push_back(res);
            end
            default:
            begin
            end
        endcase
        if (b.kind != KIND_IGNORED && !(b.kind == KIND_BUCKET && b.bslot >= NUM_BUCKETS))
        begin
            item_count++;
        end
        stim_beats.push_back(b);
    endfunction

    function automatic beat_t noise_beat(input logic [KIND_W-1:0] k);
        beat_t b;
        b.kind = k;
        b.bslot = SLOT_W'($urandom_range(0, 1023));
        b.bstart = LEN_W'($urandom_range(0, 65536));
        b.blen = LEN_W'($urandom_range(0, 65536));
        b.eslot = ESLOT_W'($urandom_range(0, 65535));
        b.ecode = $urandom;
        b.qcode = $urandom;
        return b;
    endfunction

    function automatic void put_bucket(input int slot, input int start, input int len);
        beat_t b;
        b = noise_beat(KIND_BUCKET);
        b.bslot = SLOT_W'(slot);
        b.bstart = LEN_W'(start);
        b.blen = LEN_W'(len);
        queue_beat(b);
    endfunction

    function automatic void put_entry(input int slot, input logic [CODE_W-1:0] code);
        beat_t b;
        b = noise_beat(KIND_ENTRY);
        b.eslot = ESLOT_W'(slot);
        b.ecode = code;
        queue_beat(b);
        code_pool.push_back(code);
        if (code_pool.size() > POOL_DEPTH)
        begin
            void'(code_pool.pop_front());
        end
    endfunction

    // Loads whatever the search would read that is still unloaded, then queues the
    // lookup. Filled entries often repeat the query, which grows runs of duplicates.
    function automatic void add_lookup(input logic [CODE_W-1:0] q);
        lookup_res_t res;
        int need_at;
        search_stat_e st;
        beat_t b;
        logic [15:0] low;
        st = search_dictionary(q, res, need_at);
        while (st != SEARCH_DONE)
        begin
            if (st == NEED_BUCKET)
            begin
                put_bucket(need_at, $urandom_range(0, 65536),
                           ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 32));
            end
            else
            begin
                low = 16'($urandom_range(0, 65535));
                put_entry(need_at, ($urandom_range(0, 2) == 0) ? q : {q[31:16], low});
            end
            st = search_dictionary(q, res, need_at);
        end
        b = noise_beat(KIND_LOOKUP);
        b.qcode = q;
        queue_beat(b);
    endfunction

    function automatic logic [7:0] prefix_byte();
        logic [7:0] v;
        if ($urandom_range(0, 3) != 0)
        begin
            v = 8'($urandom_range(0, 25));
            return CHAR_A + v;
        end
        v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    // A well-formed bucket: sorted codes with a shared two-byte prefix, some of them
    // repeated, loaded ahead of the bucket beat and then looked up.
    function automatic void build_bucket();
        logic [15:0]       prefix;
        logic [15:0]       low16;
        logic [CODE_W-1:0] codes [$];
        int n;
        int start;
        int low;
        int slot;
        int k;
        int i;
        int idx;
        bit reverse;
        prefix = {prefix_byte(), prefix_byte()};
        slot = bucket_of({prefix, 16'h0000});
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
        case ($urandom_range(0, 5))
            0: start = 65536 - $urandom_range(0, n);
            1: start = $urandom_range(0, 3);
            default: start = $urandom_range(0, 65536 - n);
        endcase
        low = $urandom_range(0, 300);
        for (i = 0; i < n; i++)
        begin
            if (i > 0 && $urandom_range(0, 5) != 0)
            begin
                low += $urandom_range(1, 2500);
            end
            if (low > 65535)
            begin
                low = 65535;
            end
            low16 = 16'(low);
            codes.push_back({prefix, low16});
        end
        reverse = 1'($urandom_range(0, 1));
        for (i = 0; i < n; i++)
        begin
            idx = reverse ? n - 1 - i : i;
            put_entry((start + idx) % CAPACITY, codes[idx]);
        end
        // A copy of the first code just below the bucket pulls the walk back out of it.
        if (n > 0 && start > 0 && $urandom_range(0, 3) == 0)
        begin
            put_entry((start - 1) % CAPACITY, codes[0]);
        end
        put_bucket(slot, start, n);
        k = $urandom_range(2, 8);
        for (i = 0; i < k; i++)
        begin
            low16 = 16'($urandom_range(0, 65535));
            idx = $urandom_range(0, 9);
            if (idx < 6 && n > 0)
            begin
                add_lookup(codes[$urandom_range(0, n - 1)]);
            end
            else if (idx < 9)
            begin
                add_lookup({prefix, low16});
            end
            else
            begin
                add_lookup($urandom);
            end
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic void flag_error(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("MISMATCH at cycle %0d: %s", cycles, what);
        end
    endfunction

    // Acceptance of an input beat is recorded at the rising edge and used by the sender
    // at the following falling edge.
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && !in_stall;
    end

    // Sender: holds a stalled beat unchanged, otherwise inserts a gap or presents the
    // next queued beat. Bursts without gaps come in now and then.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (stim_beats.size() != 0)
            begin
                drive_beat = stim_beats.pop_front();
                kind <= drive_beat.kind;
                bucket_slot <= drive_beat.bslot;
                bucket_start <= drive_beat.bstart;
                bucket_length <= drive_beat.blen;
                entry_slot <= drive_beat.eslot;
                entry_code <= drive_beat.ecode;
                query_code <= drive_beat.qcode;
                in_valid <= 1'b1;
                if (send_burst > 0)
                begin
                    send_burst--;
                    send_gap = 0;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    send_burst = $urandom_range(20, 80);
                    send_gap = 0;
                end
                else
                begin
                    send_gap = idle_length();
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls with quiet stretches, and once a long hold-off while the
    // sender keeps offering beats, so that the block fills up and stalls its input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (!pressure_done && results_seen >= PRESSURE_AFTER)
        begin
            pressure_done = 1'b1;
            hold_count = PRESSURE_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_count > 0)
        begin
            hold_count--;
        end
        else
        begin
            case ($urandom_range(0, 15))
                0:
                begin
                    out_stall <= 1'b0;
                    hold_count = $urandom_range(50, 200);
                end
                1, 2, 3, 4, 5:
                begin
                    out_stall <= 1'b1;
                    hold_count = idle_length();
                end
                default:
                begin
                    out_stall <= 1'b0;
                    hold_count = $urandom_range(0, 3);
                end
            endcase
        end
    end

    // Each accepted result beat is checked against the oldest lookup still waiting.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            results_seen++;
            if (awaited_lookups.size() == 0)
            begin
                flag_error($sformatf("result found=%0b index=%0d with no lookup pending",
                                     found, first_match_res));
            end
            else
            begin
                seen_lookup = awaited_lookups.pop_front();
                if (found !== seen_lookup.hit || first_match_res !== seen_lookup.index)
                begin
                    flag_error($sformatf("query %h: expected found=%0b index=%0d, got found=%0b index=%0d",
                                         seen_lookup.query, seen_lookup.hit, seen_lookup.index,
                                         found, first_match_res));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int          pick;
        int          len;
        logic [15:0] low16;

        // Bucket "other, other" straddles the top of the store: the hit at unwrapped
        // index 65536 reports 0, and the one just below reports the highest index.
        put_entry(65535, 32'h0000_0000);
        put_entry(0, 32'hFFFF_FFFF);
        put_entry(65534, 32'h0102_0304);
        put_bucket(NUM_BUCKETS - 1, 65535, 2);
        add_lookup(32'hFFFF_FFFF);
        add_lookup(32'h0000_0000);
        add_lookup(32'h7B7B_0000);

        // Three equal codes in bucket "aa": the walk back finds the first copy. With
        // index 0 equal too, it leaves the bucket and stops at index 0.
        put_entry(1, 32'h6161_0007);
        put_entry(2, 32'h6161_0007);
        put_entry(3, 32'h6161_0007);
        put_bucket(0, 1, 3);
        add_lookup(32'h6161_0007);
        put_entry(0, 32'h6161_0007);
        add_lookup(32'h6161_0007);

        // An empty bucket misses without reading the store.
        put_bucket(25 * BUCKET_COLS + 25, 40, 0);
        add_lookup(32'h7A7A_0000);

        // Largest start and largest length that the stimulus gives; the long bucket is left to the random part.
        put_bucket(1, 65536, 1);
        add_lookup(32'h6162_0000);
        put_bucket(BUCKET_COLS, 0, 65536);

        // Beats that the block drops: slots past the table and the unused kind.
        put_bucket(1023, 5, 5);
        put_bucket(NUM_BUCKETS, 7, 7);
        queue_beat(noise_beat(KIND_IGNORED));

        while (item_count < TARGET_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            low16 = 16'($urandom_range(0, 65535));
            if (pick < 55)
            begin
                build_bucket();
            end
            else if (pick < 70)
            begin
                if (code_pool.size() != 0)
                begin
                    add_lookup(code_pool[$urandom_range(0, code_pool.size() - 1)]);
                end
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    add_lookup($urandom);
                end
                else
                begin
                    add_lookup({prefix_byte(), prefix_byte(), low16});
                end
            end
            else if (pick < 88)
            begin
                put_entry($urandom_range(0, 65535), $urandom);
            end
            else if (pick < 94)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    len = ($urandom_range(0, 1) == 0) ? 65536 : $urandom_range(1024, 65536);
                end
                else
                begin
                    len = $urandom_range(0, 40);
                end
                put_bucket($urandom_range(0, NUM_BUCKETS - 1), $urandom_range(0, 65536), len);
            end
            else if (pick < 97)
            begin
                queue_beat(noise_beat(KIND_IGNORED));
            end
            else
            begin
                put_bucket($urandom_range(NUM_BUCKETS, 1023), $urandom_range(0, 65536),
                           $urandom_range(0, 65536));
            end
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every beat to go in and every lookup to come back, then give the
        // block time to show any stray result.
        while (stim_beats.size() != 0 || in_valid || awaited_lookups.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
